// ===== rtl/core/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CHR_LPAREN = 8'h28;  // (
  localparam logic [7:0] CHR_RPAREN = 8'h29;  // )
  localparam logic [7:0] CHR_LSQUARE = 8'h5B; // [
  localparam logic [7:0] CHR_RSQUARE = 8'h5D; // ]
  localparam logic [7:0] CHR_LCURLY = 8'h7B;  // {
  localparam logic [7:0] CHR_RCURLY = 8'h7D;  // }

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_ROUND  = 2'd1,
    CODE_SQUARE = 2'd2,
    CODE_CURLY  = 2'd3
  } bkt_code_t;

  // One classified character as it travels from front to back
  typedef struct packed {
    bkt_code_t open_code;   // CODE_NONE when the byte is a closer
    bkt_code_t close_code;  // partner type; CODE_NONE never matches
    logic      last;
  } bbc_item_t;

endpackage

// ===== rtl/core/bbc_ram.sv =====
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bbc_front.sv =====
`timescale 1ns / 1ps

module bbc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_code,
  input  logic             in_end_of_string,
  input  logic             q_full,
  output logic             q_push,
  output bbc_pkg::bbc_item_t q_item
);

  import bbc_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.open_code  = CODE_NONE;
    q_item.close_code = CODE_NONE;
    q_item.last       = in_end_of_string;
    unique case (in_char_code)
      CHR_LPAREN:  q_item.open_code  = CODE_ROUND;
      CHR_LSQUARE: q_item.open_code  = CODE_SQUARE;
      CHR_LCURLY:  q_item.open_code  = CODE_CURLY;
      CHR_RPAREN:  q_item.close_code = CODE_ROUND;
      CHR_RSQUARE: q_item.close_code = CODE_SQUARE;
      CHR_RCURLY:  q_item.close_code = CODE_CURLY;
      default: begin
        // any other byte is a closer that matches nothing
        q_item.close_code = CODE_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bbc_queue.sv =====
`timescale 1ns / 1ps

module bbc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bbc_pkg::bbc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output bbc_pkg::bbc_item_t head
);

  import bbc_pkg::*;

  bbc_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full  = (fill_r == 2'd2);
  assign valid = (fill_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bbc_stack.sv =====
`timescale 1ns / 1ps

module bbc_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bbc_pkg::bbc_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_balanced,
  output logic               out_overflowed
);

  import bbc_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mismatch_r, mismatch_nxt;
  logic              overflow_r, overflow_nxt;
  bkt_code_t         top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              balanced_r, balanced_nxt;
  logic              overflowed_r, overflowed_nxt;

  logic              go;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  below_idx;
  logic [1:0]        below_code;
  logic [CNT_W-1:0]  cnt_step;
  logic              mis_step;
  logic              ovf_step;

  // the RAM holds every entry; top_r mirrors the entry at count-1 and the
  // read port always presents the entry below it
  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (q_head.open_code),
    .raddr (rd_addr),
    .rdata (below_code)
  );

  // hold a final character while the previous result is still waiting
  assign go    = q_valid && !(q_head.last && out_valid_r && out_stall);
  assign q_pop = go;

  always_comb begin
    wr_en    = 1'b0;
    cnt_step = count_r;
    mis_step = mismatch_r;
    ovf_step = overflow_r;
    top_nxt  = top_r;

    if (go) begin
      if (q_head.open_code != CODE_NONE) begin
        if (count_r == CNT_W'(STACK_DEPTH)) begin
          ovf_step = 1'b1;
        end else begin
          wr_en    = 1'b1;
          top_nxt  = q_head.open_code;
          cnt_step = count_r + CNT_W'(1);
        end
      end else if (count_r == '0) begin
        mis_step = 1'b1;
      end else if (q_head.close_code != CODE_NONE && top_r == q_head.close_code) begin
        cnt_step = count_r - CNT_W'(1);
        top_nxt  = bkt_code_t'(below_code);
      end else begin
        mis_step = 1'b1;
      end
    end

    count_nxt    = cnt_step;
    mismatch_nxt = mis_step;
    overflow_nxt = ovf_step;

    out_valid_nxt  = out_valid_r && out_stall;
    balanced_nxt   = balanced_r;
    overflowed_nxt = overflowed_r;

    if (go && q_head.last) begin
      out_valid_nxt  = 1'b1;
      balanced_nxt   = !mis_step && !ovf_step && (cnt_step == '0);
      overflowed_nxt = ovf_step;
      count_nxt      = '0;
      mismatch_nxt   = 1'b0;
      overflow_nxt   = 1'b0;
    end

    // fetch the entry that will sit below the new top
    below_idx = count_nxt - CNT_W'(2);
    rd_addr   = below_idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mismatch_r  <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      mismatch_r  <= mismatch_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    balanced_r   <= balanced_nxt;
    overflowed_r <= overflowed_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_balanced   = balanced_r;
  assign out_overflowed = overflowed_r;

endmodule

// ===== rtl/core/bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
// Path: the result of a string is registered in the queue, then in the output
// register, after its last character is accepted.
// Throughput: one character per cycle while in_stall is low; the stack engine does
// one push or pop per cycle against a RAM with one write and one registered read port.
// Reset: synchronous active-low rst_n empties the queue, stack count and flags;
// the stack RAM is not cleared, as only entries written in the current string are read.

module bracket_balance_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_balanced,
  output logic       out_overflowed
);

  import bbc_pkg::*;

  bbc_item_t push_item;
  bbc_item_t head_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;

  bbc_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  bbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  bbc_stack u_stack (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_balanced   (out_balanced),
    .out_overflowed (out_overflowed)
  );

endmodule

// ===== bench/bracket_balance_checker_top_test.sv =====
`timescale 1ns / 1ps

module bracket_balance_checker_top_test;
  import bbc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int CHAR_TARGET = 1700;
  localparam int PAUSE_EVERY = 500;

  typedef struct packed {
    logic balanced;
    logic overflowed;
  } verdict_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    verdict_t   verdict;
  } char_row_t;

  localparam verdict_t NOT_BALANCED = '{1'b0, 1'b0};
  localparam verdict_t BALANCED     = '{1'b1, 1'b0};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic       out_balanced;
  logic       out_overflowed;

  bracket_balance_checker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_balanced     (out_balanced),
    .out_overflowed   (out_overflowed)
  );

  // Nesting predictor: its own copy of the stack and the sticky flags
  bkt_code_t   open_types [STACK_DEPTH];
  int unsigned open_fill = 0;
  bit          saw_mismatch = 0;
  bit          saw_overflow = 0;

  verdict_t    expected_verdicts [$];
  byte unsigned text_buf [$];

  int unsigned chars_sent = 0;
  int unsigned verdicts_checked = 0;
  int unsigned balanced_verdicts = 0;
  int unsigned overflow_verdicts = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 0;

  // Short strings covering each bracket kind, the byte extremes and the failure cases
  char_row_t directed_rows [23] = '{
    '{CHR_LPAREN,  1'b1, 1'b1, NOT_BALANCED},  // opener never closed
    '{CHR_RPAREN,  1'b1, 1'b1, NOT_BALANCED},  // closer with nothing open
    '{CHR_LPAREN,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RPAREN,  1'b1, 1'b1, BALANCED},
    '{CHR_LSQUARE, 1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RSQUARE, 1'b1, 1'b1, BALANCED},
    '{CHR_LCURLY,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RCURLY,  1'b1, 1'b1, BALANCED},
    '{CHR_LPAREN,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RSQUARE, 1'b1, 1'b1, NOT_BALANCED},  // wrong partner
    '{8'h61,       1'b1, 1'b1, NOT_BALANCED},  // plain letter is a stray closer
    '{8'h00,       1'b1, 1'b1, NOT_BALANCED},
    '{8'hFF,       1'b1, 1'b1, NOT_BALANCED},
    '{CHR_LPAREN,  1'b0, 1'b0, NOT_BALANCED},  // stack keeps working after a failure
    '{CHR_LSQUARE, 1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RPAREN,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RSQUARE, 1'b1, 1'b0, NOT_BALANCED},
    '{CHR_LPAREN,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_LSQUARE, 1'b0, 1'b0, NOT_BALANCED},
    '{CHR_LCURLY,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RCURLY,  1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RSQUARE, 1'b0, 1'b0, NOT_BALANCED},
    '{CHR_RPAREN,  1'b1, 1'b1, BALANCED}
  };

  always #10 clk = ~clk;

  function automatic bkt_code_t opener_type(logic [7:0] ch);
    case (ch)
      CHR_LPAREN:  return CODE_ROUND;
      CHR_LSQUARE: return CODE_SQUARE;
      CHR_LCURLY:  return CODE_CURLY;
      default:     return CODE_NONE;
    endcase
  endfunction

  function automatic bkt_code_t partner_type(logic [7:0] ch);
    case (ch)
      CHR_RPAREN:  return CODE_ROUND;
      CHR_RSQUARE: return CODE_SQUARE;
      CHR_RCURLY:  return CODE_CURLY;
      default:     return CODE_NONE;
    endcase
  endfunction

  function automatic logic [7:0] opener_char(bkt_code_t t);
    case (t)
      CODE_ROUND:  return CHR_LPAREN;
      CODE_SQUARE: return CHR_LSQUARE;
      default:     return CHR_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(bkt_code_t t);
    case (t)
      CODE_ROUND:  return CHR_RPAREN;
      CODE_SQUARE: return CHR_RSQUARE;
      default:     return CHR_RCURLY;
    endcase
  endfunction

  function automatic logic [7:0] any_bracket();
    case ($urandom_range(0, 5))
      0:       return CHR_LPAREN;
      1:       return CHR_RPAREN;
      2:       return CHR_LSQUARE;
      3:       return CHR_RSQUARE;
      4:       return CHR_LCURLY;
      default: return CHR_RCURLY;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one, none during quiet stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic predict_char(input logic [7:0] ch, input logic last,
                              output bit has_verdict, output verdict_t v);
    bkt_code_t opened;
    bkt_code_t wanted;
    opened = opener_type(ch);
    wanted = partner_type(ch);
    has_verdict = 1'b0;
    v = NOT_BALANCED;
    if (opened != CODE_NONE) begin
      // drop the opener when the stack is full
      if (open_fill >= STACK_DEPTH) saw_overflow = 1'b1;
      else begin
        open_types[open_fill] = opened;
        open_fill++;
      end
    end else if (open_fill == 0 || wanted == CODE_NONE ||
                 open_types[open_fill - 1] != wanted) begin
      saw_mismatch = 1'b1;
    end else begin
      open_fill--;
    end
    if (last) begin
      has_verdict = 1'b1;
      v.balanced = !saw_mismatch && !saw_overflow && open_fill == 0;
      v.overflowed = saw_overflow;
      open_fill = 0;
      saw_mismatch = 1'b0;
      saw_overflow = 1'b0;
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input verdict_t typed_verdict);
    bit has_verdict;
    verdict_t v;
    int gap;
    in_valid <= 1'b1;
    in_char_code <= ch;
    in_end_of_string <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(ch, last, has_verdict, v);
    if (has_verdict)
      expected_verdicts.insert(expected_verdicts.size(), typed ? typed_verdict : v);
    chars_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_char(text_buf[i], i == n - 1, 1'b0, NOT_BALANCED);
    text_buf.delete();
  endtask

  // Hold the sender until every outstanding verdict has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // Well-formed string; eager opens everything first for the deepest nesting
  task automatic build_nested(input int pairs, input int max_depth, input bit eager);
    bkt_code_t open_stack [$];
    bkt_code_t t;
    int opens_left;
    opens_left = pairs;
    while (opens_left > 0 || open_stack.size() > 0) begin
      if (opens_left > 0 && (open_stack.size() == 0 ||
          (open_stack.size() < max_depth && (eager || $urandom_range(0, 1) == 1)))) begin
        t = bkt_code_t'($urandom_range(1, 3));
        open_stack.insert(open_stack.size(), t);
        text_buf.insert(text_buf.size(), opener_char(t));
        opens_left--;
      end else begin
        text_buf.insert(text_buf.size(), closer_char(open_stack.pop_back()));
      end
    end
  endtask

  task automatic break_text();
    int pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 4))
      0: text_buf[pos] = any_bracket();
      1: text_buf[pos] = $urandom_range(0, 255);
      2: if (text_buf.size() > 1) text_buf.delete(pos);
      3: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
      default: text_buf.insert(pos, any_bracket());
    endcase
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(0, 1) == 1) text_buf.insert(text_buf.size(), any_bracket());
      else text_buf.insert(text_buf.size(), $urandom_range(0, 255));
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
    else begin
      out_stall <= !quiet && ($urandom_range(0, 2) == 0);
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Compare each verdict transaction with the oldest outstanding expectation
  always @(posedge clk) begin : check_verdict
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected verdict at cycle %0d: balanced=%0b overflowed=%0b",
                   cycle_count, out_balanced, out_overflowed);
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (want.balanced) balanced_verdicts++;
        if (want.overflowed) overflow_verdicts++;
        if (out_balanced !== want.balanced || out_overflowed !== want.overflowed) begin
          error_count++;
          if (error_count <= 10)
            $display("Verdict %0d wrong: balanced exp %0b got %0b, overflowed exp %0b got %0b",
                     verdicts_checked, want.balanced, out_balanced,
                     want.overflowed, out_overflowed);
        end
      end
    end
  end

  initial begin
    int r;
    int next_pause;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'h00;
    in_end_of_string = 1'b0;
    out_stall = 1'b0;
    next_pause = PAUSE_EVERY;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].verdict);
    wait_drain();

    // fill the stack exactly, then push one past it
    build_nested(STACK_DEPTH, STACK_DEPTH, 1'b1);
    send_text();
    build_nested(STACK_DEPTH + 1, STACK_DEPTH + 1, 1'b1);
    send_text();

    while (chars_sent < CHAR_TARGET) begin
      r = $urandom_range(0, 199);
      if (r < 110) begin
        build_nested($urandom_range(1, 8), $urandom_range(1, 6), 1'b0);
      end else if (r < 150) begin
        build_nested($urandom_range(1, 8), $urandom_range(1, 6), 1'b0);
        break_text();
      end else if (r < 195) begin
        build_noise();
      end else begin
        build_nested($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3), STACK_DEPTH + 3,
                     $urandom_range(0, 1));
      end
      send_text();
      if (chars_sent >= next_pause) begin
        wait_drain();
        next_pause += PAUSE_EVERY;
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d characters through the checker; %0d string verdicts compared",
             chars_sent, verdicts_checked);
    $display("  %0d balanced, %0d overflowed, nesting taken to and past depth %0d",
             balanced_verdicts, overflow_verdicts, STACK_DEPTH);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== bracket_balance_checker_top.f =====
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_front.sv
rtl/core/bbc_queue.sv
rtl/core/bbc_stack.sv
rtl/core/bracket_balance_checker_top.sv
bench/bracket_balance_checker_top_test.sv
